// File: rtl/qrs_pkg.sv
// Shared types and codes for the quadratic root solver.
`timescale 1ns / 1ps
package qrs_pkg;

   typedef enum logic [2:0] {
      OUT_ANY  = 3'd0,
      OUT_NONE = 3'd1,
      OUT_ONE  = 3'd2,
      OUT_TWO  = 3'd3,
      OUT_CPLX = 3'd4
   } outcome_type;

   // Control that travels with a request through the dividers.
   typedef struct packed {
      outcome_type outcome;
      logic        mirror;   // first root = +quotient of lane 1, second = -quotient
   } res_ctl_type;

endpackage

// File: rtl/qrs_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module qrs_isqrt #(
   parameter int SQ    = 49,
   parameter int TAG_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [2*SQ-1:0]   in_rad,
   input  logic [TAG_W-1:0]  in_tag,
   output logic              out_valid,
   output logic [SQ-1:0]     out_root,
   output logic [TAG_W-1:0]  out_tag
);

   logic              v_ff    [0:SQ];
   logic [TAG_W-1:0]  tag_ff  [0:SQ];
   logic [2*SQ-1:0]   rad_ff  [0:SQ];
   logic [SQ+1:0]     rem_ff  [0:SQ];
   logic [SQ-1:0]     root_ff [0:SQ];

   logic [SQ+3:0]     t_w     [1:SQ];
   logic [SQ+3:0]     trial_w [1:SQ];
   logic              ge_w    [1:SQ];
   logic [2*SQ-1:0]   rad_in  [1:SQ];
   logic [SQ+1:0]     rem_in  [1:SQ];
   logic [SQ-1:0]     root_in [1:SQ];

   always_comb begin
      for (int k = 1; k <= SQ; k++) begin
         t_w[k]     = {rem_ff[k-1], rad_ff[k-1][2*SQ-1 -: 2]};
         trial_w[k] = {2'b00, root_ff[k-1], 2'b01};
         ge_w[k]    = (t_w[k] >= trial_w[k]);
         rem_in[k]  = ge_w[k] ? (SQ+2)'(t_w[k] - trial_w[k]) : t_w[k][SQ+1:0];
         root_in[k] = {root_ff[k-1][SQ-2:0], ge_w[k]};
         rad_in[k]  = {rad_ff[k-1][2*SQ-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SQ; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k <= SQ; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0]  <= in_tag;
         rad_ff[0]  <= in_rad;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         for (int k = 1; k <= SQ; k++) begin
            tag_ff[k]  <= tag_ff[k-1];
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign out_valid = v_ff[SQ];
   assign out_root  = root_ff[SQ];
   assign out_tag   = tag_ff[SQ];

endmodule

// File: rtl/qrs_rdiv.sv
// Two-lane pipelined rounded divider, one quotient bit per stage.
`timescale 1ns / 1ps
module qrs_rdiv #(
   parameter int NW = 50,
   parameter int DW = 33
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  qrs_pkg::res_ctl_type in_ctl,
   input  logic [NW-1:0]        in_num [0:1],
   input  logic [DW-1:0]        in_den [0:1],
   input  logic                 in_neg [0:1],
   output logic                 out_valid,
   output qrs_pkg::res_ctl_type out_ctl,
   output logic [NW+1:0]        out_quo [0:1],
   output logic                 out_neg [0:1]
);
   import qrs_pkg::*;

   localparam int QW = NW + 2;
   localparam int RW = DW + 1;

   logic          v_ff   [0:QW];
   res_ctl_type   ctl_ff [0:QW];
   logic          neg_ff [0:QW][0:1];
   logic [QW-1:0] nq_ff  [0:QW][0:1];
   logic [RW-1:0] rem_ff [0:QW][0:1];
   logic [RW-1:0] den_ff [0:QW][0:1];

   logic [QW-1:0] nq0_in  [0:1];
   logic [RW:0]   t_w     [1:QW][0:1];
   logic          ge_w    [1:QW][0:1];
   logic [RW-1:0] rem_in  [1:QW][0:1];
   logic [QW-1:0] nq_in   [1:QW][0:1];

   // rounding to nearest: (2n + d) / (2d)
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         nq0_in[l] = QW'({in_num[l], 1'b0}) + QW'(in_den[l]);
      end
      for (int k = 1; k <= QW; k++) begin
         for (int l = 0; l < 2; l++) begin
            t_w[k][l]    = {rem_ff[k-1][l], nq_ff[k-1][l][QW-1]};
            ge_w[k][l]   = (t_w[k][l] >= {1'b0, den_ff[k-1][l]});
            rem_in[k][l] = ge_w[k][l] ? RW'(t_w[k][l] - {1'b0, den_ff[k-1][l]})
                                      : t_w[k][l][RW-1:0];
            nq_in[k][l]  = {nq_ff[k-1][l][QW-2:0], ge_w[k][l]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k <= QW; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff[0] <= in_ctl;
         for (int l = 0; l < 2; l++) begin
            neg_ff[0][l] <= in_neg[l];
            nq_ff[0][l]  <= nq0_in[l];
            rem_ff[0][l] <= '0;
            den_ff[0][l] <= {in_den[l], 1'b0};
         end
         for (int k = 1; k <= QW; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
            for (int l = 0; l < 2; l++) begin
               neg_ff[k][l] <= neg_ff[k-1][l];
               nq_ff[k][l]  <= nq_in[k][l];
               rem_ff[k][l] <= rem_in[k][l];
               den_ff[k][l] <= den_ff[k-1][l];
            end
         end
      end
   end

   assign out_valid  = v_ff[QW];
   assign out_ctl    = ctl_ff[QW];
   assign out_quo[0] = nq_ff[QW][0];
   assign out_quo[1] = nq_ff[QW][1];
   assign out_neg[0] = neg_ff[QW][0];
   assign out_neg[1] = neg_ff[QW][1];

endmodule

// File: rtl/quadratic_root_solver_top.sv
// Quadratic root solver: top level with input skid, discriminant, sqrt and divide pipes.
//
// Usage: a request on req_ carries coef_a, coef_b, coef_c (signed fixed point,
// FRAC_BITS fraction bits). One result per request comes out on rsp_ in order:
// outcome code and overflow on rsp_tuser, the two roots on rsp_tdata.
// Pipeline: 4 front stages + (SQ+1) sqrt stages + 1 select stage + (QW+1)
// divider stages + 1 output stage, where SQ = (2*DATA_WIDTH+1+2*FRAC_BITS+1)/2
// and QW = max(DATA_WIDTH+FRAC_BITS, SQ)+3: 109 stages at 32/16.
// Throughput: one request per cycle while not stalled; the length is set by the bit-per-stage
// square root and the two bit-per-stage dividers.
// Stall: while rsp_tvalid is high and rsp_tready is low the whole pipeline holds;
// one more request is taken into a skid register, then req_tready drops (it is registered).
// Reset: synchronous, clears all valid bits and the skid; payload is not reset.
`timescale 1ns / 1ps
module quadratic_root_solver_top #(
   parameter int FRAC_BITS  = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // coef_a, coef_b, coef_c
   input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]      req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // root_first, root_second
   output logic [((2*DATA_WIDTH+7)/8)*8-1:0]      rsp_tdata,
   // outcome, overflow
   output logic [3:0]                             rsp_tuser
);
   import qrs_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int DW  = 2*W + 1;
   localparam int SQ  = (DW + 2*F + 1) / 2;
   localparam int NBW = W + F;
   localparam int NW  = ((NBW > SQ) ? NBW : SQ) + 1;
   localparam int QW  = NW + 2;
   localparam int OW  = ((2*W+7)/8)*8;
   localparam logic [QW-1:0] Q_HALF = {{(QW-1){1'b0}}, 1'b1} << (W-1);

   typedef struct packed {
      logic          a_neg;
      logic          b_neg;
      logic          c_neg;
      logic [W-1:0]  a_mag;
      logic [W-1:0]  b_mag;
      logic [W-1:0]  c_mag;
      logic          az;
      logic          bz;
      logic          cz;
      logic          disc_neg;
      logic          disc_zero;
   } stage_type;

   logic en;
   logic req_fire;
   assign en       = !rsp_tvalid || rsp_tready;
   assign req_fire = req_tvalid && req_tready;

   // ---------------- input skid ----------------
   logic         skid_v_ff, skid_v_in;
   logic [W-1:0] skid_a_ff, skid_b_ff, skid_c_ff;
   logic         s0_v_ff;
   logic [W-1:0] s0_a_ff, s0_b_ff, s0_c_ff;

   assign skid_v_in  = en ? (skid_v_ff && req_fire) : (skid_v_ff || req_fire);
   assign req_tready = !skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
         s0_v_ff   <= 1'b0;
      end else begin
         skid_v_ff <= skid_v_in;
         if (en) s0_v_ff <= skid_v_ff || req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (!en || skid_v_ff)) begin
         skid_a_ff <= req_tdata[W-1:0];
         skid_b_ff <= req_tdata[2*W-1:W];
         skid_c_ff <= req_tdata[3*W-1:2*W];
      end
      if (en) begin
         s0_a_ff <= skid_v_ff ? skid_a_ff : req_tdata[W-1:0];
         s0_b_ff <= skid_v_ff ? skid_b_ff : req_tdata[2*W-1:W];
         s0_c_ff <= skid_v_ff ? skid_c_ff : req_tdata[3*W-1:2*W];
      end
   end

   // ---------------- magnitudes, products, discriminant ----------------
   stage_type    st1_in, st1_ff, st2_ff, st3_in, st3_ff;
   logic         s1_v_ff, s2_v_ff, s3_v_ff;
   logic [2*W-1:0] b2_ff, ac_ff;
   logic [DW:0]  ac4_w, disc_w;
   logic [DW-1:0] disc_mag_w;
   logic [2*SQ-1:0] rad_ff, rad_in;

   always_comb begin
      st1_in           = '0;
      st1_in.a_neg     = s0_a_ff[W-1];
      st1_in.b_neg     = s0_b_ff[W-1];
      st1_in.c_neg     = s0_c_ff[W-1];
      st1_in.a_mag     = s0_a_ff[W-1] ? (~s0_a_ff + 1'b1) : s0_a_ff;
      st1_in.b_mag     = s0_b_ff[W-1] ? (~s0_b_ff + 1'b1) : s0_b_ff;
      st1_in.c_mag     = s0_c_ff[W-1] ? (~s0_c_ff + 1'b1) : s0_c_ff;
      st1_in.az        = (s0_a_ff == '0);
      st1_in.bz        = (s0_b_ff == '0);
      st1_in.cz        = (s0_c_ff == '0);
   end

   // -4AC is negative when A and C share a sign
   always_comb begin
      ac4_w      = (DW+1)'({ac_ff, 2'b00});
      disc_w     = (st2_ff.a_neg == st2_ff.c_neg) ? ((DW+1)'(b2_ff) - ac4_w)
                                                  : ((DW+1)'(b2_ff) + ac4_w);
      disc_mag_w = disc_w[DW] ? DW'(-disc_w) : disc_w[DW-1:0];
      st3_in           = st2_ff;
      st3_in.disc_neg  = disc_w[DW];
      st3_in.disc_zero = (disc_w == '0);
      rad_in           = (2*SQ)'({disc_mag_w, {(2*F){1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st1_ff <= st1_in;
         st2_ff <= st1_ff;
         b2_ff  <= st1_ff.b_mag * st1_ff.b_mag;
         ac_ff  <= st1_ff.a_mag * st1_ff.c_mag;
         st3_ff <= st3_in;
         rad_ff <= rad_in;
      end
   end

   // ---------------- square root ----------------
   logic          sq_v;
   logic [SQ-1:0] sq_root;
   stage_type     sq_st;

   qrs_isqrt #(
      .SQ    (SQ),
      .TAG_W ($bits(stage_type))
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_v_ff),
      .in_rad    (rad_ff),
      .in_tag    (st3_ff),
      .out_valid (sq_v),
      .out_root  (sq_root),
      .out_tag   (sq_st)
   );

   // ---------------- operand select ----------------
   logic [NBW-1:0] nb_mag_w;
   logic           nb_neg_w;
   logic [NW:0]    nbs_w, sum_w, diff_w;
   logic [NW-1:0]  sum_mag_w, diff_mag_w, s_ext_w;
   logic [W:0]     twoa_w;
   logic [NW-1:0]  n_in  [0:1];
   logic [W:0]     d_in  [0:1];
   logic           g_in  [0:1];
   res_ctl_type    ctl_in;

   logic           s4_v_ff;
   logic [NW-1:0]  n_ff  [0:1];
   logic [W:0]     d_ff  [0:1];
   logic           g_ff  [0:1];
   res_ctl_type    ctl_ff;

   always_comb begin
      nb_mag_w   = {sq_st.b_mag, {F{1'b0}}};
      nb_neg_w   = !sq_st.b_neg && !sq_st.bz;
      s_ext_w    = NW'(sq_root);
      nbs_w      = nb_neg_w ? (NW+1)'(-(NW+1)'(nb_mag_w)) : (NW+1)'(nb_mag_w);
      sum_w      = nbs_w + (NW+1)'(s_ext_w);
      diff_w     = nbs_w - (NW+1)'(s_ext_w);
      sum_mag_w  = sum_w[NW]  ? NW'(-sum_w)  : sum_w[NW-1:0];
      diff_mag_w = diff_w[NW] ? NW'(-diff_w) : diff_w[NW-1:0];
      twoa_w     = {sq_st.a_mag, 1'b0};

      n_in[0] = '0;  d_in[0] = (W+1)'(1);  g_in[0] = 1'b0;
      n_in[1] = '0;  d_in[1] = (W+1)'(1);  g_in[1] = 1'b0;
      ctl_in.outcome = OUT_ANY;
      ctl_in.mirror  = 1'b0;

      if (sq_st.az) begin
         if (sq_st.bz) begin
            ctl_in.outcome = sq_st.cz ? OUT_ANY : OUT_NONE;
         end else begin
            ctl_in.outcome = OUT_ONE;
            n_in[0] = NW'({sq_st.c_mag, {F{1'b0}}});
            d_in[0] = {1'b0, sq_st.b_mag};
            g_in[0] = (!sq_st.c_neg && !sq_st.cz) ^ sq_st.b_neg;
         end
      end else if (sq_st.cz && !sq_st.bz) begin
         ctl_in.outcome = OUT_TWO;
         n_in[1] = NW'(nb_mag_w);
         d_in[1] = {1'b0, sq_st.a_mag};
         g_in[1] = nb_neg_w ^ sq_st.a_neg;
      end else if (sq_st.bz && !sq_st.cz) begin
         n_in[1] = s_ext_w;
         d_in[1] = twoa_w;
         if (sq_st.disc_neg) begin
            ctl_in.outcome = OUT_CPLX;
         end else begin
            ctl_in.outcome = OUT_TWO;
            ctl_in.mirror  = 1'b1;
         end
      end else if (sq_st.disc_zero) begin
         ctl_in.outcome = OUT_ONE;
         n_in[0] = NW'(nb_mag_w);
         d_in[0] = twoa_w;
         g_in[0] = nb_neg_w ^ sq_st.a_neg;
      end else if (!sq_st.disc_neg) begin
         ctl_in.outcome = OUT_TWO;
         n_in[0] = sum_mag_w;
         d_in[0] = twoa_w;
         g_in[0] = sum_w[NW] ^ sq_st.a_neg;
         n_in[1] = diff_mag_w;
         d_in[1] = twoa_w;
         g_in[1] = diff_w[NW] ^ sq_st.a_neg;
      end else begin
         ctl_in.outcome = OUT_CPLX;
         n_in[0] = NW'(nb_mag_w);
         d_in[0] = twoa_w;
         g_in[0] = nb_neg_w ^ sq_st.a_neg;
         n_in[1] = s_ext_w;
         d_in[1] = twoa_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s4_v_ff <= sq_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff <= ctl_in;
         for (int l = 0; l < 2; l++) begin
            n_ff[l] <= n_in[l];
            d_ff[l] <= d_in[l];
            g_ff[l] <= g_in[l];
         end
      end
   end

   // ---------------- dividers ----------------
   logic          dv_v;
   res_ctl_type   dv_ctl;
   logic [QW-1:0] dv_quo [0:1];
   logic          dv_neg [0:1];

   qrs_rdiv #(
      .NW (NW),
      .DW (W+1)
   ) u_rdiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_v_ff),
      .in_ctl    (ctl_ff),
      .in_num    (n_ff),
      .in_den    (d_ff),
      .in_neg    (g_ff),
      .out_valid (dv_v),
      .out_ctl   (dv_ctl),
      .out_quo   (dv_quo),
      .out_neg   (dv_neg)
   );

   // ---------------- saturate and output ----------------
   function automatic logic [W:0] emit(input logic [QW-1:0] q, input logic neg);
      logic [QW-1:0] lim;
      lim = neg ? Q_HALF : (Q_HALF - 1'b1);
      if (q > lim) begin
         emit = {1'b1, neg, {(W-1){!neg}}};
      end else begin
         emit = {1'b0, (neg ? W'(-q) : q[W-1:0])};
      end
   endfunction

   logic [W:0]   r1_w, r2_w;
   logic         rsp_v_ff;
   outcome_type  rsp_outcome_ff;
   logic [W-1:0] rsp_r1_ff, rsp_r2_ff;
   logic         rsp_ovf_ff;

   always_comb begin
      if (dv_ctl.mirror) begin
         r1_w = emit(dv_quo[1], 1'b0);
         r2_w = emit(dv_quo[1], 1'b1);
      end else begin
         r1_w = emit(dv_quo[0], dv_neg[0]);
         r2_w = emit(dv_quo[1], dv_neg[1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         rsp_v_ff <= dv_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_outcome_ff <= dv_ctl.outcome;
         rsp_r1_ff      <= r1_w[W-1:0];
         rsp_r2_ff      <= r2_w[W-1:0];
         rsp_ovf_ff     <= r1_w[W] || r2_w[W];
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = OW'({rsp_r2_ff, rsp_r1_ff});
   assign rsp_tuser  = {rsp_ovf_ff, rsp_outcome_ff};

`ifndef SYNTHESIS
   a_skid_flow: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !skid_v_ff && en) |=> s0_v_ff)
      else $error("request lost at pipeline entry");

   a_no_root_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && (rsp_outcome_ff == OUT_ANY || rsp_outcome_ff == OUT_NONE))
      |-> (rsp_r1_ff == '0 && rsp_r2_ff == '0 && !rsp_ovf_ff))
      else $error("roots reported for an equation without roots");

   a_cplx_imag_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && rsp_outcome_ff == OUT_CPLX) |-> !rsp_r2_ff[W-1])
      else $error("negative imaginary magnitude");

   a_one_root: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && rsp_outcome_ff == OUT_ONE) |-> (rsp_r2_ff == '0))
      else $error("second root set for a single root");
`endif

endmodule

// File: test/quadratic_root_solver_top_test.sv
// Self-checking stream testbench for the quadratic root solver, with exact root prediction.
`timescale 1ns / 1ps
module quadratic_root_solver_top_test;
   import qrs_pkg::*;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_WIDTH = 32;
   localparam int LATENCY    = 108;

   typedef logic [127:0] wide_type;
   typedef struct {
      bit       neg;
      wide_type m;
   } fix_type;
   typedef struct {
      outcome_type outcome;
      logic [31:0] root_first;
      logic [31:0] root_second;
      logic        overflow;
   } roots_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [3:0]  rsp_tuser;

   roots_type expected_roots[$];
   int     errors;
   bit     hold_rsp;
   int     hold_cycles;
   int     burst_left;

   quadratic_root_solver_top #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic fix_type to_fix(logic [31:0] raw);
      fix_type     f;
      logic [31:0] mag;
      mag   = raw[31] ? -raw : raw;
      f.neg = raw[31];
      f.m   = wide_type'(mag);
      return f;
   endfunction

   function automatic fix_type fix_add(fix_type x, fix_type y);
      fix_type r;
      if (x.neg == y.neg) begin
         r.neg = x.neg; r.m = x.m + y.m;
      end else if (x.m >= y.m) begin
         r.neg = x.neg; r.m = x.m - y.m;
      end else begin
         r.neg = y.neg; r.m = y.m - x.m;
      end
      if (r.m == 0) r.neg = 0;
      return r;
   endfunction

   // round to nearest, ties away from zero
   function automatic fix_type round_div(fix_type n, fix_type d);
      fix_type r;
      r.m   = (2 * n.m + d.m) / (2 * d.m);
      r.neg = (n.neg != d.neg) && (r.m != 0);
      return r;
   endfunction

   function automatic wide_type int_sqrt(wide_type n);
      wide_type rem, res, b;
      rem = n; res = 0; b = 128'd1 << 126;
      while (b != 0) begin
         if (rem >= res + b) begin
            rem = rem - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] clamp_root(fix_type v, inout logic ovf);
      wide_type lim;
      lim = v.neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (v.m > lim) begin
         ovf = 1;
         return v.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return v.neg ? -v.m[31:0] : v.m[31:0];
   endfunction

   function automatic roots_type solve_roots(logic [95:0] coefs);
      fix_type   a, b, c, r1, r2, nc, b2, ac4, disc, s, ns, twoa, abstwoa, nb, mag;
      bit        az, bz, cz;
      roots_type res;
      a = to_fix(coefs[31:0]); b = to_fix(coefs[63:32]); c = to_fix(coefs[95:64]);
      az = a.m == 0; bz = b.m == 0; cz = c.m == 0;
      r1 = '{0, 0}; r2 = '{0, 0};
      res.overflow = 0;
      if (az) begin
         if (bz) begin
            res.outcome = cz ? OUT_ANY : OUT_NONE;
         end else begin
            res.outcome = OUT_ONE;
            nc.neg = !c.neg && !cz;
            nc.m = c.m << FRAC_BITS;
            r1 = round_div(nc, b);
         end
      end else begin
         b2.neg = 0; b2.m = b.m * b.m;
         ac4.neg = (a.neg == c.neg); ac4.m = (a.m * c.m) << 2;
         disc = fix_add(b2, ac4);
         s.neg = 0; s.m = int_sqrt(disc.m << (2 * FRAC_BITS));
         twoa.neg = a.neg; twoa.m = a.m << 1;
         abstwoa = twoa; abstwoa.neg = 0;
         nb.neg = !b.neg && !bz; nb.m = b.m << FRAC_BITS;
         if (cz && !bz) begin
            res.outcome = OUT_TWO;
            r2 = round_div(nb, a);
         end else if (bz && !cz) begin
            mag = round_div(s, abstwoa);
            if (disc.neg) begin
               res.outcome = OUT_CPLX;
               r2 = mag;
            end else begin
               res.outcome = OUT_TWO;
               r1 = mag; r2 = mag; r2.neg = mag.m != 0;
            end
         end else if (disc.m == 0) begin
            res.outcome = OUT_ONE;
            r1 = round_div(nb, twoa);
         end else if (!disc.neg) begin
            res.outcome = OUT_TWO;
            ns = s; ns.neg = s.m != 0;
            r1 = round_div(fix_add(nb, s), twoa);
            r2 = round_div(fix_add(nb, ns), twoa);
         end else begin
            res.outcome = OUT_CPLX;
            r1 = round_div(nb, twoa);
            r2 = round_div(s, abstwoa);
         end
      end
      res.root_first  = clamp_root(r1, res.overflow);
      res.root_second = clamp_root(r2, res.overflow);
      return res;
   endfunction

   // request monitor and response checker
   always @(posedge clock) begin
      roots_type exp_r;
      if (!reset) begin
         if (req_tvalid && req_tready) expected_roots.push_back(solve_roots(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_roots.size() == 0) begin
               $display("%0t: unexpected response tdata=%h tuser=%h", $time, rsp_tdata,
                        rsp_tuser);
               errors++;
            end else begin
               exp_r = expected_roots.pop_front();
               if (rsp_tuser[2:0] !== exp_r.outcome) begin
                  $display("%0t: outcome expected %0d actual %0d", $time, exp_r.outcome,
                           rsp_tuser[2:0]);
                  errors++;
               end
               if (rsp_tdata[31:0] !== exp_r.root_first) begin
                  $display("%0t: root_first expected %h actual %h", $time,
                           exp_r.root_first, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[63:32] !== exp_r.root_second) begin
                  $display("%0t: root_second expected %h actual %h", $time,
                           exp_r.root_second, rsp_tdata[63:32]);
                  errors++;
               end
               if (rsp_tuser[3] !== exp_r.overflow) begin
                  $display("%0t: overflow expected %b actual %b", $time, exp_r.overflow,
                           rsp_tuser[3]);
                  errors++;
               end
            end
         end
      end
   end

   // receiver stall pattern, with an optional long hold
   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_tready <= 0;
         hold_cycles++;
         if (hold_cycles >= 400) hold_rsp <= 0;
      end else begin
         rsp_tready <= ($time / 2000) % 3 == 0 ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   task automatic send_request(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      req_tvalid <= 1;
      req_tdata  <= {c, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      @(posedge clock);
      while (expected_roots.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return $urandom_range(0, 3) << 16;
         2: return -($urandom_range(1, 3) << 16);
         3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         4: return $signed($urandom_range(0, 8191)) - 4096;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_request(0, 0, 0);
      send_request(0, 0, 32'h0001_0000);
      send_request(0, 32'h0002_0000, 32'hFFFC_0000);
      send_request(0, 1, 32'h7FFF_FFFF);
      send_request(32'h0001_0000, 32'hFFFD_0000, 0);
      send_request(1, 32'h7FFF_FFFF, 0);
      send_request(32'h0001_0000, 0, 32'h0004_0000);
      send_request(32'hFFFF_0000, 0, 32'hFFFC_0000);
      send_request(32'h0001_0000, 0, 32'hFFFC_0000);
      send_request(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
      send_request(32'h0001_0000, 0, 0);
      send_request(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);
      send_request(32'h0001_0000, 32'h0002_0000, 32'h0005_0000);
      send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001);
      send_request(1, 0, 32'h8000_0000);
      send_request(1, 0, 32'h7FFF_FFFF);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_random(int count);
      repeat (count) send_request(rand_coef(), rand_coef(), rand_coef());
   endtask

   task automatic test_backpressure();
      hold_cycles = 0;
      hold_rsp <= 1;
      repeat (150) send_request($urandom, $urandom, $urandom);
   endtask

   task automatic test_drain_pause();
      test_random(30);
      wait_drained();
      test_random(30);
   endtask

   initial begin
      reset = 1; req_tvalid = 0; req_tdata = 0; rsp_tready = 0;
      errors = 0; hold_rsp = 0; hold_cycles = 0; burst_left = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random(150);
      test_backpressure();
      test_drain_pause();
      test_random(150);
      wait_drained();
      repeat (LATENCY + 20) @(posedge clock);
      if (errors == 0 && expected_roots.size() == 0) begin
         $display("== PASS ==");
      end else begin
         if (expected_roots.size() != 0)
            $display("%0t: %0d responses missing", $time, expected_roots.size());
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("%0t: timeout", $time);
      $display("== FAIL ==");
      $finish;
   end

endmodule
